>>> rtl/core/fpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-phase process sequencer package
// Shared defaults, fixed widths, stage and register codes, and the command
// and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fpps_pkg;

   localparam int DURATION_BITS_DEF = 24;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int STEP_BITS         = 16;
   localparam int STAGE_BITS        = 3;
   localparam int CSR_INDEX_BITS    = 2;

   typedef enum logic [STAGE_BITS-1:0] {
      STAGE_IDLE      = 3'd0,
      STAGE_TENSION   = 3'd1,
      STAGE_FORMING   = 3'd2,
      STAGE_HOLD      = 3'd3,
      STAGE_UNLOADING = 3'd4,
      STAGE_COMPLETE  = 3'd5,
      STAGE_INVALID   = 3'd6
   } stage_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TENSION   = 2'd0,
      CSR_FORMING   = 2'd1,
      CSR_HOLD      = 2'd2,
      CSR_UNLOADING = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic sum_f;
      logic sum_h;
      logic sum_t;
      logic set_invalid;
      logic latch_invalid;
      logic advance;
      logic classify;
      logic div_start_prog;
      logic div_start_local;
      logic div_step;
      logic store_prog;
      logic store_local;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic ok;
      logic total_zero;
      logic dt_zero;
      logic done_stage;
      logic reach_total;
      logic need_local;
      logic div_busy;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/core/four_phase_process_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-phase process sequencer
// Each request carries a tick increment; the unit advances elapsed time
// through the tension, forming, hold and unloading phases and answers
// with the stage, elapsed ticks and four Q1.FB fractions.
//
// Requests enter on req_valid/req_ready, responses leave on
// rsp_valid/rsp_ready. Durations are written through csr_write_en,
// csr_index and csr_wdata; the user must write them only while no
// request is in flight, as the block itself does not enforce it.
// A request that lands in the tension, forming or unloading phase needs
// two restoring divisions on one shared divider. The hold phase needs
// one division; a step that completes the run, a zero step, and a
// completed or invalid run need none. One request is worked at a time;
// the next one is accepted in the cycle after the response is loaded,
// so no new request is taken before the last one has been answered.
// A stalled receiver holds the response register; a finished request
// then waits until the register frees. Reset clears the run state and
// sets every duration to 1000 ticks.
// ----------------------------------------------------------------------------
module four_phase_process_sequencer_unit #(
   parameter int DURATION_BITS = fpps_pkg::DURATION_BITS_DEF,
   parameter int FRACTION_BITS = fpps_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fpps_pkg::STEP_BITS-1:0]      req_time_step,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fpps_pkg::STAGE_BITS-1:0]     rsp_stage,
   output logic                                rsp_valid_flag,
   output logic [DURATION_BITS+1:0]            rsp_elapsed_ticks,
   output logic [FRACTION_BITS:0]              rsp_overall_progress,
   output logic [FRACTION_BITS:0]              rsp_tension_level,
   output logic [FRACTION_BITS:0]              rsp_bend_level,
   output logic [FRACTION_BITS:0]              rsp_release_level,
   input  logic                                csr_write_en,
   input  logic [fpps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DURATION_BITS-1:0]            csr_wdata
);

   fpps_pkg::cmd_type    cmd;
   fpps_pkg::status_type status;

   fpps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   fpps_datapath #(
      .DB(DURATION_BITS),
      .FB(FRACTION_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_time_step       (req_time_step),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_stage           (rsp_stage),
      .rsp_valid_flag      (rsp_valid_flag),
      .rsp_elapsed_ticks   (rsp_elapsed_ticks),
      .rsp_overall_progress(rsp_overall_progress),
      .rsp_tension_level   (rsp_tension_level),
      .rsp_bend_level      (rsp_bend_level),
      .rsp_release_level   (rsp_release_level)
   );

endmodule

>>> rtl/core/fpps_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider that forms (num << FB) / den, one quotient bit per cycle
// while step is high, saturating to one if num reaches den or den is zero.
// ----------------------------------------------------------------------------
module fpps_divider #(
   parameter int NUM_W = 27,
   parameter int FB    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             step,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] den,
   output logic             busy,
   output logic [FB:0]      quotient
);

   localparam int CNT_W = $clog2(FB + 1);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] den_ff, den_in;
   logic [FB-1:0]    q_ff, q_in;
   logic             bypass_ff, bypass_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [NUM_W:0]   rem2;
   logic [NUM_W:0]   diff;
   logic             fits;

   always_comb begin
      rem2      = {rem_ff, 1'b0};
      fits      = rem2 >= {1'b0, den_ff};
      diff      = rem2 - {1'b0, den_ff};
      rem_in    = rem_ff;
      den_in    = den_ff;
      q_in      = q_ff;
      bypass_in = bypass_ff;
      count_in  = count_ff;
      if (start) begin
         rem_in    = num;
         den_in    = den;
         q_in      = '0;
         bypass_in = (num >= den) || (den == '0);
         count_in  = CNT_W'(FB);
      end else if (step && busy) begin
         rem_in   = fits ? diff[NUM_W-1:0] : rem2[NUM_W-1:0];
         q_in     = {q_ff[FB-2:0], fits};
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      q_ff      <= q_in;
      bypass_ff <= bypass_in;
   end

   assign busy     = count_ff != '0;
   assign quotient = bypass_ff ? {1'b1, {FB{1'b0}}} : {1'b0, q_ff};

endmodule

>>> rtl/core/fpps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-phase process sequencer datapath
// Duration registers, phase boundaries, process state, the shared fraction
// divider and the registered response.
// ----------------------------------------------------------------------------
module fpps_datapath #(
   parameter int DB = fpps_pkg::DURATION_BITS_DEF,
   parameter int FB = fpps_pkg::FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fpps_pkg::cmd_type                    cmd,
   output fpps_pkg::status_type                 status,
   input  logic [fpps_pkg::STEP_BITS-1:0]       req_time_step,
   input  logic                                 csr_write_en,
   input  logic [fpps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [DB-1:0]                        csr_wdata,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [fpps_pkg::STAGE_BITS-1:0]      rsp_stage,
   output logic                                 rsp_valid_flag,
   output logic [DB+1:0]                        rsp_elapsed_ticks,
   output logic [FB:0]                          rsp_overall_progress,
   output logic [FB:0]                          rsp_tension_level,
   output logic [FB:0]                          rsp_bend_level,
   output logic [FB:0]                          rsp_release_level
);

   localparam int SUM_W = DB + 2;
   localparam int EL_W  = ((SUM_W > fpps_pkg::STEP_BITS) ? SUM_W : fpps_pkg::STEP_BITS) + 1;
   localparam int SW    = fpps_pkg::STAGE_BITS;

   localparam logic [DB-1:0] DUR_RESET = DB'(1000);
   localparam logic [FB:0]   ONE_FRAC  = {1'b1, {FB{1'b0}}};

   logic [DB-1:0]   td_ff, td_in, fd_ff, fd_in, hd_ff, hd_in, ud_ff, ud_in;
   logic [fpps_pkg::STEP_BITS-1:0] dt_ff, dt_in;
   logic [SUM_W-1:0] f_end_ff, f_end_in, h_end_ff, h_end_in, total_ff, total_in;
   logic [EL_W-1:0] elapsed_ff, elapsed_in;
   logic [SW-1:0]   phase_ff, phase_in;
   logic            ok_ff, ok_in;
   logic [FB:0]     progress_ff, progress_in;
   logic [FB:0]     tension_ff, tension_in;
   logic [FB:0]     bend_ff, bend_in;
   logic [FB:0]     release_ff, release_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]   rsp_stage_ff, rsp_stage_in;
   logic            rsp_ok_ff, rsp_ok_in;
   logic [DB+1:0]   rsp_elapsed_ff, rsp_elapsed_in;
   logic [FB:0]     rsp_prog_ff, rsp_prog_in;
   logic [FB:0]     rsp_tension_ff, rsp_tension_in;
   logic [FB:0]     rsp_bend_ff, rsp_bend_in;
   logic [FB:0]     rsp_release_ff, rsp_release_in;

   logic            lt_t, lt_f, lt_h, lt_total;
   logic [EL_W-1:0] local_num, local_den, div_num, div_den;
   logic            div_busy;
   logic [FB:0]     div_q;

   assign lt_t     = elapsed_ff < EL_W'(td_ff);
   assign lt_f     = elapsed_ff < EL_W'(f_end_ff);
   assign lt_h     = elapsed_ff < EL_W'(h_end_ff);
   assign lt_total = elapsed_ff < EL_W'(total_ff);

   always_comb begin
      case (phase_ff)
         fpps_pkg::STAGE_TENSION: begin
            local_num = elapsed_ff;
            local_den = EL_W'(td_ff);
         end
         fpps_pkg::STAGE_FORMING: begin
            local_num = elapsed_ff - EL_W'(td_ff);
            local_den = EL_W'(fd_ff);
         end
         fpps_pkg::STAGE_UNLOADING: begin
            local_num = elapsed_ff - EL_W'(h_end_ff);
            local_den = EL_W'(ud_ff);
         end
         default: begin
            local_num = elapsed_ff;
            local_den = EL_W'(total_ff);
         end
      endcase
      div_num = cmd.div_start_local ? local_num : elapsed_ff;
      div_den = cmd.div_start_local ? local_den : EL_W'(total_ff);
   end

   fpps_divider #(
      .NUM_W(EL_W),
      .FB   (FB)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start_prog || cmd.div_start_local),
      .step    (cmd.div_step),
      .num     (div_num),
      .den     (div_den),
      .busy    (div_busy),
      .quotient(div_q)
   );

   always_comb begin
      td_in = td_ff;
      fd_in = fd_ff;
      hd_in = hd_ff;
      ud_in = ud_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            fpps_pkg::CSR_TENSION:   td_in = csr_wdata;
            fpps_pkg::CSR_FORMING:   fd_in = csr_wdata;
            fpps_pkg::CSR_HOLD:      hd_in = csr_wdata;
            fpps_pkg::CSR_UNLOADING: ud_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      dt_in       = cmd.capture ? req_time_step : dt_ff;
      f_end_in    = cmd.sum_f ? SUM_W'(td_ff) + SUM_W'(fd_ff) : f_end_ff;
      h_end_in    = cmd.sum_h ? f_end_ff + SUM_W'(hd_ff) : h_end_ff;
      total_in    = cmd.sum_t ? h_end_ff + SUM_W'(ud_ff) : total_ff;
      elapsed_in  = elapsed_ff;
      phase_in    = phase_ff;
      ok_in       = ok_ff;
      progress_in = progress_ff;
      tension_in  = tension_ff;
      bend_in     = bend_ff;
      release_in  = release_ff;
      if (cmd.set_invalid) begin
         phase_in = fpps_pkg::STAGE_INVALID;
      end
      if (cmd.latch_invalid) begin
         phase_in = fpps_pkg::STAGE_INVALID;
         ok_in    = 1'b0;
      end
      if (cmd.advance) begin
         elapsed_in = elapsed_ff + EL_W'(dt_ff);
      end
      if (cmd.classify) begin
         priority if (lt_t) begin
            phase_in   = fpps_pkg::STAGE_TENSION;
            bend_in    = '0;
            release_in = '0;
         end else if (lt_f) begin
            phase_in   = fpps_pkg::STAGE_FORMING;
            tension_in = ONE_FRAC;
            release_in = '0;
         end else if (lt_h) begin
            phase_in   = fpps_pkg::STAGE_HOLD;
            tension_in = ONE_FRAC;
            bend_in    = ONE_FRAC;
            release_in = '0;
         end else if (lt_total) begin
            phase_in = fpps_pkg::STAGE_UNLOADING;
            bend_in  = ONE_FRAC;
         end else begin
            phase_in    = fpps_pkg::STAGE_COMPLETE;
            elapsed_in  = EL_W'(total_ff);
            progress_in = ONE_FRAC;
            tension_in  = '0;
            bend_in     = ONE_FRAC;
            release_in  = ONE_FRAC;
         end
      end
      if (cmd.store_prog) begin
         progress_in = div_q;
      end
      if (cmd.store_local) begin
         case (phase_ff)
            fpps_pkg::STAGE_TENSION: tension_in = div_q;
            fpps_pkg::STAGE_FORMING: bend_in = div_q;
            fpps_pkg::STAGE_UNLOADING: begin
               release_in = div_q;
               tension_in = ONE_FRAC - div_q;
            end
            default: tension_in = tension_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_stage_in   = rsp_stage_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_prog_in    = rsp_prog_ff;
      rsp_tension_in = rsp_tension_ff;
      rsp_bend_in    = rsp_bend_ff;
      rsp_release_in = rsp_release_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_stage_in   = phase_ff;
         rsp_ok_in      = ok_ff;
         rsp_elapsed_in = elapsed_ff[DB+1:0];
         rsp_prog_in    = progress_ff;
         rsp_tension_in = tension_ff;
         rsp_bend_in    = bend_ff;
         rsp_release_in = release_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         td_ff        <= DUR_RESET;
         fd_ff        <= DUR_RESET;
         hd_ff        <= DUR_RESET;
         ud_ff        <= DUR_RESET;
         elapsed_ff   <= '0;
         phase_ff     <= fpps_pkg::STAGE_IDLE;
         ok_ff        <= 1'b1;
         progress_ff  <= '0;
         tension_ff   <= '0;
         bend_ff      <= '0;
         release_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         td_ff        <= td_in;
         fd_ff        <= fd_in;
         hd_ff        <= hd_in;
         ud_ff        <= ud_in;
         elapsed_ff   <= elapsed_in;
         phase_ff     <= phase_in;
         ok_ff        <= ok_in;
         progress_ff  <= progress_in;
         tension_ff   <= tension_in;
         bend_ff      <= bend_in;
         release_ff   <= release_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff          <= dt_in;
      f_end_ff       <= f_end_in;
      h_end_ff       <= h_end_in;
      total_ff       <= total_in;
      rsp_stage_ff   <= rsp_stage_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_prog_ff    <= rsp_prog_in;
      rsp_tension_ff <= rsp_tension_in;
      rsp_bend_ff    <= rsp_bend_in;
      rsp_release_ff <= rsp_release_in;
   end

   always_comb begin
      status.ok          = ok_ff;
      status.total_zero  = total_ff == '0;
      status.dt_zero     = dt_ff == '0;
      status.done_stage  = phase_ff == fpps_pkg::STAGE_COMPLETE;
      status.reach_total = !lt_total;
      status.need_local  = (phase_ff == fpps_pkg::STAGE_TENSION) ||
                           (phase_ff == fpps_pkg::STAGE_FORMING) ||
                           (phase_ff == fpps_pkg::STAGE_UNLOADING);
      status.div_busy    = div_busy;
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_stage            = rsp_stage_ff;
   assign rsp_valid_flag       = rsp_ok_ff;
   assign rsp_elapsed_ticks    = rsp_elapsed_ff;
   assign rsp_overall_progress = rsp_prog_ff;
   assign rsp_tension_level    = rsp_tension_ff;
   assign rsp_bend_level       = rsp_bend_ff;
   assign rsp_release_level    = rsp_release_ff;

endmodule

>>> rtl/core/fpps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-phase process sequencer controller
// One-hot state machine that steps the datapath through boundary sums,
// special-case checks, classification and the two fraction divisions.
// ----------------------------------------------------------------------------
module fpps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fpps_pkg::status_type status,
   output fpps_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_SUM_F     = 9'b000000010,
      ST_SUM_H     = 9'b000000100,
      ST_SUM_T     = 9'b000001000,
      ST_CHECK     = 9'b000010000,
      ST_CLASSIFY  = 9'b000100000,
      ST_DIV_PROG  = 9'b001000000,
      ST_DIV_LOCAL = 9'b010000000,
      ST_RESPOND   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SUM_F;
            end
         end
         ST_SUM_F: begin
            cmd.sum_f = 1'b1;
            state_in  = ST_SUM_H;
         end
         ST_SUM_H: begin
            cmd.sum_h = 1'b1;
            state_in  = ST_SUM_T;
         end
         ST_SUM_T: begin
            cmd.sum_t = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!status.ok) begin
               cmd.set_invalid = 1'b1;
               state_in        = ST_RESPOND;
            end else if (status.total_zero) begin
               cmd.latch_invalid = 1'b1;
               state_in          = ST_RESPOND;
            end else if (status.dt_zero || status.done_stage) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            if (status.reach_total) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.div_start_prog = 1'b1;
               state_in           = ST_DIV_PROG;
            end
         end
         ST_DIV_PROG: begin
            if (status.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.store_prog = 1'b1;
               if (status.need_local) begin
                  cmd.div_start_local = 1'b1;
                  state_in            = ST_DIV_LOCAL;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_DIV_LOCAL: begin
            if (status.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.store_local = 1'b1;
               state_in        = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
